### hw/rtl/mtd_pkg.sv
// Shared types, constants and the Morse code table for the Morse text decoder.
// Used by every module under hw/rtl; depends on nothing else.
package mtd_pkg;

   // Byte values with a fixed meaning in the text stream and in results.
   localparam logic [7:0] SEPARATOR_BYTE = 8'h2F;  // '/'
   localparam logic [7:0] UNKNOWN_CHAR   = 8'h3F;  // '?'
   localparam logic [7:0] DOT_BYTE       = 8'h2E;  // '.'
   localparam logic [7:0] DASH_BYTE      = 8'h2D;  // '-'
   localparam logic [7:0] SPACE_BYTE     = 8'h20;  // ' '
   localparam logic [7:0] BANG_BYTE      = 8'h21;  // '!'

   // The longest dot/dash code in the table has seven marks.
   localparam int MAX_CODE_LEN = 7;
   localparam int LEN_W        = 3;
   localparam int ROM_SIZE     = 49;

   // Request and response items.
   typedef struct packed {
      logic [7:0] code_byte;
      logic       end_of_text;
   } req_item_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       matched;
   } rsp_item_type;

   // Class of one buffered symbol. A mark is a dot or a dash.
   typedef enum logic [1:0] {
      SYM_MARK,
      SYM_SPACE,
      SYM_BANG,
      SYM_OTHER
   } sym_class_type;

   // Kind of a finished code handed from the front end to the lookup.
   typedef enum logic [1:0] {
      JOB_NONE,
      JOB_MARKS,
      JOB_SPACE,
      JOB_BANG
   } job_kind_type;

   // A finished code. The pattern holds one bit per mark, a dash as 1,
   // with the last mark in bit 0 and zeros above the code length.
   typedef struct packed {
      job_kind_type              kind;
      logic [LEN_W-1:0]          len;
      logic [MAX_CODE_LEN-1:0]   pattern;
   } job_type;

   typedef struct packed {
      logic [LEN_W-1:0]          len;
      logic [MAX_CODE_LEN-1:0]   pattern;
      logic [7:0]                char_byte;
   } rom_entry_type;

   // Queue status seen by both sides of the decoupling queue.
   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   // Dot/dash code table. Entries shadowed by an earlier one with the same
   // code are left out, so every code here is unique and at most one hits.
   localparam rom_entry_type CODE_ROM [ROM_SIZE] = '{
      '{3'd2, 7'b0000001, 8'h61},  // .-      a
      '{3'd4, 7'b0000101, 8'hA5},  // .-.-
      '{3'd4, 7'b0001000, 8'h62},  // -...    b
      '{3'd4, 7'b0001010, 8'h63},  // -.-.    c
      '{3'd5, 7'b0010100, 8'h86},  // -.-..
      '{3'd3, 7'b0000100, 8'h64},  // -..     d
      '{3'd1, 7'b0000000, 8'h65},  // .       e
      '{3'd5, 7'b0000100, 8'hA9},  // ..-..
      '{3'd4, 7'b0000010, 8'h66},  // ..-.    f
      '{3'd3, 7'b0000110, 8'h67},  // --.     g
      '{3'd4, 7'b0000000, 8'h68},  // ....    h
      '{3'd2, 7'b0000000, 8'h69},  // ..      i
      '{3'd4, 7'b0000111, 8'h6A},  // .---    j
      '{3'd3, 7'b0000101, 8'h6B},  // -.-     k
      '{3'd4, 7'b0000100, 8'h6C},  // .-..    l
      '{3'd5, 7'b0001001, 8'h88},  // .-..-
      '{3'd2, 7'b0000011, 8'h6D},  // --      m
      '{3'd2, 7'b0000010, 8'h6E},  // -.      n
      '{3'd5, 7'b0011011, 8'hE4},  // --.--
      '{3'd3, 7'b0000111, 8'h6F},  // ---     o
      '{3'd4, 7'b0001110, 8'hA2},  // ---.
      '{3'd4, 7'b0000110, 8'h70},  // .--.    p
      '{3'd4, 7'b0001101, 8'h71},  // --.-    q
      '{3'd3, 7'b0000010, 8'h72},  // .-.     r
      '{3'd3, 7'b0000000, 8'h73},  // ...     s
      '{3'd7, 7'b0001000, 8'h98},  // ...-...
      '{3'd1, 7'b0000001, 8'h74},  // -       t
      '{3'd3, 7'b0000001, 8'h75},  // ..-     u
      '{3'd4, 7'b0000001, 8'h76},  // ...-    v
      '{3'd3, 7'b0000011, 8'h77},  // .--     w
      '{3'd4, 7'b0001001, 8'h78},  // -..-    x
      '{3'd4, 7'b0001011, 8'h79},  // -.--    y
      '{3'd4, 7'b0001100, 8'h7A},  // --..    z
      '{3'd5, 7'b0011001, 8'hBE},  // --..-
      '{3'd6, 7'b0010101, 8'h2E},  // .-.-.-  period
      '{3'd6, 7'b0110011, 8'h2C},  // --..--  comma
      '{3'd6, 7'b0001100, 8'h3F},  // ..--..  question mark
      '{3'd6, 7'b0111000, 8'h3A},  // ---...  colon
      '{3'd6, 7'b0100001, 8'h2D},  // -....-  hyphen
      '{3'd5, 7'b0011111, 8'h30},  // -----   0
      '{3'd5, 7'b0001111, 8'h31},  // .----   1
      '{3'd5, 7'b0000111, 8'h32},  // ..---   2
      '{3'd5, 7'b0000011, 8'h33},  // ...--   3
      '{3'd5, 7'b0000001, 8'h34},  // ....-   4
      '{3'd5, 7'b0000000, 8'h35},  // .....   5
      '{3'd5, 7'b0010000, 8'h36},  // -....   6
      '{3'd5, 7'b0011000, 8'h37},  // --...   7
      '{3'd5, 7'b0011100, 8'h38},  // ---..   8
      '{3'd5, 7'b0011110, 8'h39}   // ----.   9
   };

   // Sort one text byte into its symbol class.
   function automatic sym_class_type classify(logic [7:0] b);
      sym_class_type c;
      if (b == DOT_BYTE || b == DASH_BYTE) begin
         c = SYM_MARK;
      end else if (b == SPACE_BYTE) begin
         c = SYM_SPACE;
      end else if (b == BANG_BYTE) begin
         c = SYM_BANG;
      end else begin
         c = SYM_OTHER;
      end
      return c;
   endfunction

endpackage

### hw/rtl/mtd_front.sv
// Front end of the Morse text decoder: takes text bytes and builds the pending code.
// Depends on mtd_pkg for the item, symbol and job types.
module mtd_front import mtd_pkg::*; #(
   parameter int MAX_SYMBOLS = 15
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_item_type item,
   output logic         push,
   output job_type      job
);

   localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX      = CNT_W'(MAX_SYMBOLS);
   localparam logic [CNT_W-1:0] CNT_CODE_MAX = CNT_W'(MAX_CODE_LEN);
   localparam logic [CNT_W-1:0] CNT_ONE      = CNT_W'(1);

   // Only the first seven symbols can ever decide a match, so the buffer
   // keeps them as a mark pattern plus a few summary flags.
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    overflow_ff, overflow_in;
   logic [MAX_CODE_LEN-1:0] pattern_ff, pattern_in;
   logic                    all_marks_ff, all_marks_in;
   sym_class_type           first_class_ff, first_class_in;

   logic          is_sep;
   logic          pending;
   logic          flush;
   logic          symbol;
   sym_class_type sym_class;

   // Classify the incoming request.
   always_comb begin
      is_sep    = (item.code_byte == SEPARATOR_BYTE);
      pending   = (count_ff != '0) || overflow_ff;
      flush     = item.end_of_text ? pending : is_sep;
      symbol    = !item.end_of_text && !is_sep;
      sym_class = classify(item.code_byte);
      push      = accept && flush;
   end

   // Summarize the pending code for the lookup.
   always_comb begin
      job.len     = count_ff[LEN_W-1:0];
      job.pattern = pattern_ff;
      if (overflow_ff || count_ff == '0 || count_ff > CNT_CODE_MAX) begin
         job.kind = JOB_NONE;
      end else if (count_ff == CNT_ONE) begin
         unique case (first_class_ff)
            SYM_MARK:  job.kind = JOB_MARKS;
            SYM_SPACE: job.kind = JOB_SPACE;
            SYM_BANG:  job.kind = JOB_BANG;
            SYM_OTHER: job.kind = JOB_NONE;
         endcase
      end else begin
         job.kind = all_marks_ff ? JOB_MARKS : JOB_NONE;
      end
   end

   // Update the code buffer: clear on a flush, append or saturate on a symbol.
   always_comb begin
      count_in       = count_ff;
      overflow_in    = overflow_ff;
      pattern_in     = pattern_ff;
      all_marks_in   = all_marks_ff;
      first_class_in = first_class_ff;
      if (push) begin
         count_in     = '0;
         overflow_in  = 1'b0;
         pattern_in   = '0;
         all_marks_in = 1'b1;
      end else if (accept && symbol) begin
         if (count_ff != CNT_MAX) begin
            count_in     = count_ff + 1'b1;
            pattern_in   = {pattern_ff[MAX_CODE_LEN-2:0], item.code_byte == DASH_BYTE};
            all_marks_in = all_marks_ff && (sym_class == SYM_MARK);
            if (count_ff == '0) begin
               first_class_in = sym_class;
            end
         end else begin
            overflow_in = 1'b1;
         end
      end
   end

   // Buffer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         overflow_ff    <= 1'b0;
         pattern_ff     <= '0;
         all_marks_ff   <= 1'b1;
         first_class_ff <= SYM_OTHER;
      end else begin
         count_ff       <= count_in;
         overflow_ff    <= overflow_in;
         pattern_ff     <= pattern_in;
         all_marks_ff   <= all_marks_in;
         first_class_ff <= first_class_in;
      end
   end

   // A flush always leaves an empty buffer behind.
   assert property (@(posedge clock) disable iff (reset)
      push |=> (count_ff == '0) && !overflow_ff)
      else $error("code buffer not cleared after a flush");

   // Overflow can only be flagged once the buffer is full.
   assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> count_ff == CNT_MAX)
      else $error("overflow flagged with a buffer that is not full");

   // The symbol count saturates at the buffer size.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("symbol count beyond the buffer size");

endmodule

### hw/rtl/mtd_queue.sv
// Short queue of finished codes between the front end and the lookup stage.
// Depends on mtd_pkg for the job and queue status types.
module mtd_queue import mtd_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Status and head of the queue.
   always_comb begin
      status.valid = (count_ff != '0);
      status.full  = (count_ff == CNT_FULL);
      head_job     = slot_ff[rd_ptr_ff];
   end

   // Pointer and occupancy update, wrapping at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   // The front end never writes into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("push into a full queue");

   // The lookup never takes from an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> status.valid)
      else $error("pop from an empty queue");

   // Occupancy stays within the queue depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue occupancy beyond its depth");

endmodule

### hw/rtl/mtd_back.sv
// Lookup stage of the Morse text decoder: matches a finished code against the table.
// Depends on mtd_pkg for the job, response and table definitions.
module mtd_back import mtd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  job_type          head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_item_type     rsp_data
);

   // Compare a code against every table entry at once; codes are unique,
   // so the hits can simply be ORed together.
   function automatic rsp_item_type lookup(job_type j);
      rsp_item_type r;
      logic [7:0]   char_acc;
      logic         hit;
      logic         eq;
      char_acc = '0;
      hit      = 1'b0;
      for (int k = 0; k < ROM_SIZE; k++) begin
         eq       = (CODE_ROM[k].len == j.len) && (CODE_ROM[k].pattern == j.pattern);
         char_acc = char_acc | ({8{eq}} & CODE_ROM[k].char_byte);
         hit      = hit | eq;
      end
      unique case (j.kind)
         JOB_SPACE: r = rsp_item_type'{SPACE_BYTE, 1'b1};
         JOB_BANG:  r = rsp_item_type'{BANG_BYTE, 1'b1};
         JOB_MARKS: r = hit ? rsp_item_type'{char_acc, 1'b1}
                            : rsp_item_type'{UNKNOWN_CHAR, 1'b0};
         JOB_NONE:  r = rsp_item_type'{UNKNOWN_CHAR, 1'b0};
      endcase
      return r;
   endfunction

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff;
   logic         out_ready;

   // Take the next code whenever the output register is free or being emptied.
   always_comb begin
      out_ready    = !rsp_valid_ff || !rsp_stall;
      pop          = q_status.valid && out_ready;
      rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);
   end

   // Output valid register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= lookup(head_job);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A code taken from the queue shows up as a response on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("popped code did not reach the output register");

   // A miss always carries the substitute character.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.matched) |-> rsp_data_ff.char_byte == UNKNOWN_CHAR)
      else $error("unmatched response without the substitute character");

   // A stalled response stays valid and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("stalled response dropped or changed");

endmodule

### hw/rtl/morse_text_decoder.sv
// Top level of the Morse text decoder: front end, code queue and lookup stage.
// Depends on mtd_pkg, mtd_front, mtd_queue and mtd_back.
//
// The decoder takes one byte of Morse text per clock cycle while req_stall is
// low. Bytes other than '/' are collected into the pending code; a '/' or an
// end-of-text request with a pending code ends it, and the character for that
// code reaches the response channel through the code queue and the output
// register (a lowercase letter, a digit, punctuation, a space or a code-page
// byte, or '?' with matched low when the code is unknown or longer than the
// buffer holds). Finished codes wait in a small queue of QUEUE_DEPTH entries
// ahead of the registered table lookup, so request bytes keep flowing while a
// response is stalled; req_stall rises only when that queue is full.
module morse_text_decoder import mtd_pkg::*; #(
   parameter int MAX_SYMBOLS = 15,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   queue_status_type q_status;
   logic             req_accept;
   logic             push;
   logic             pop;
   job_type          push_job;
   job_type          head_job;

   // Requests are held off only while the code queue is full.
   assign req_stall  = q_status.full;
   assign req_accept = req_valid && !req_stall;

   // Front end: collects symbols and emits finished codes.
   mtd_front #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .item   (req_data),
      .push   (push),
      .job    (push_job)
   );

   // Queue of finished codes.
   mtd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // Table lookup and response register.
   mtd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
